@@ design/rigid_body_euler_step_defines.svh @@
// Assertion macros shared by the rigid body Euler step checkers.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef RIGID_BODY_EULER_STEP_DEFINES_SVH
`define RIGID_BODY_EULER_STEP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define RBES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define RBES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rbes_pkg.sv @@
// Package of the rigid body Euler step: payload types, register indexes,
// step codes and the controller-to-datapath command. No dependencies.
package rbes_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_SPEED   = 3'd4;

  localparam logic [31:0] INV_MASS_RST  = 32'd65536;
  localparam logic [30:0] MAX_SPEED_RST = 31'h7FFF_FFFF;
  localparam logic [15:0] FRICTION_RST  = 16'd3840;

  // 0.001 in Q32.32, for the squared knockback length. The 1.0 test only
  // looks at whether the upper word of the squared length is zero.
  localparam logic [63:0] LENSQ_MIN_DECAY = 64'd4294967;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               load_knockback;
    logic signed [31:0] knockback_x;
    logic signed [31:0] knockback_y;
    logic        [15:0] step_time;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_position_x;
    logic signed [31:0] new_position_y;
    logic signed [31:0] new_heading;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic               knockback_active;
  } out_item_t;

  // One code per cycle of the computation. Most issue one product on the
  // shared multiplier and retire the product issued the cycle before; the
  // knockback write-back and the last position step issue none.
  typedef enum logic [3:0] {
    STEP_MUL_AX  = 4'd0,
    STEP_MUL_AY  = 4'd1,
    STEP_MUL_DVX = 4'd2,
    STEP_MUL_DVY = 4'd3,
    STEP_MUL_FD  = 4'd4,
    STEP_SQ_PX   = 4'd5,
    STEP_SQ_PY   = 4'd6,
    STEP_DEC_X   = 4'd7,
    STEP_DEC_Y   = 4'd8,
    STEP_SQ_NX   = 4'd9,
    STEP_SQ_NY   = 4'd10,
    STEP_PUSH    = 4'd11,
    STEP_MUL_HD  = 4'd12,
    STEP_MUL_TX  = 4'd13,
    STEP_MUL_TY  = 4'd14,
    STEP_POS_Y   = 4'd15
  } step_t;

  typedef struct packed {
    logic  capture;
    logic  run;
    step_t step;
    logic  load_out;
  } rbes_cmd_t;

endpackage

@@ design/rbes_stream_if.sv @@
// Valid/ready stream interface carrying one payload of type item_t.
// Depends on nothing; payload types come from rbes_pkg at instantiation.
interface rbes_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/rbes_ctrl.sv @@
// Controller of the rigid body Euler step: handshakes and step sequencing.
// Depends on rbes_pkg.
module rbes_ctrl import rbes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rbes_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       out_valid_next;
  logic       accept;
  logic       load_out;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // The result moves to the output register once the slot is free.
  assign load_out = (state == ST_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cnt_next = cnt + 4'd1;
        if (step_t'(cnt) == STEP_POS_Y) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign cmd.capture  = accept;
  assign cmd.run      = (state == ST_CALC);
  assign cmd.step     = step_t'(cnt);
  assign cmd.load_out = load_out;

endmodule

@@ design/rbes_datapath.sv @@
// Datapath of the rigid body Euler step: configuration registers, body
// state, one shared 33x33 multiplier and the write-back logic per step.
// Depends on rbes_pkg.
module rbes_datapath import rbes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  rbes_cmd_t             cmd,
  input  in_item_t              in_item,
  output out_item_t             out_item
);

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v[67:31] == '0 || v[67:31] == '1) begin
      r = v[31:0];
    end else if (v[67]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] v,
                                                    input logic [30:0] lim);
    logic signed [32:0] pos;
    logic signed [32:0] neg;
    logic signed [31:0] r;
    pos = {2'b00, lim};
    neg = -pos;
    if (33'(v) > pos) begin
      r = pos[31:0];
    end else if (33'(v) < neg) begin
      r = neg[31:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration
  logic        [31:0] inv_mass;
  logic        [30:0] max_speed_x;
  logic        [30:0] max_speed_y;
  logic        [15:0] friction;
  logic signed [31:0] ang_speed;

  // Body state
  logic signed [31:0] vel_x, vel_y, push_x, push_y;

  // Working registers
  in_item_t           item;
  logic signed [65:0] prod;
  logic signed [31:0] tmp_a, tmp_b;
  logic        [31:0] fric_dt;
  logic        [63:0] lensq;
  logic               decay;
  logic signed [32:0] travel;
  logic signed [31:0] pos_x_n, pos_y_n, head_n;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p_q16, p_q24;
  logic signed [31:0] gain;
  logic        [63:0] lensq_sum;
  logic signed [32:0] dt_s;

  assign dt_s      = {17'd0, item.step_time};
  assign p_q16     = prod >>> 16;
  assign p_q24     = prod >>> 24;
  assign gain      = sat32(68'(p_q16));
  assign lensq_sum = lensq + prod[63:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      STEP_MUL_AX: begin
        mul_a = 33'(item.force_x);
        mul_b = {1'b0, inv_mass};
      end
      STEP_MUL_AY: begin
        mul_a = 33'(item.force_y);
        mul_b = {1'b0, inv_mass};
      end
      STEP_MUL_DVX: begin
        mul_a = 33'(tmp_a);
        mul_b = dt_s;
      end
      STEP_MUL_DVY: begin
        mul_a = 33'(tmp_b);
        mul_b = dt_s;
      end
      STEP_MUL_FD: begin
        mul_a = {17'd0, friction};
        mul_b = dt_s;
      end
      STEP_SQ_PX: begin
        mul_a = 33'(push_x);
        mul_b = 33'(push_x);
      end
      STEP_SQ_PY: begin
        mul_a = 33'(push_y);
        mul_b = 33'(push_y);
      end
      STEP_DEC_X: begin
        mul_a = 33'(push_x);
        mul_b = {1'b0, fric_dt};
      end
      STEP_DEC_Y: begin
        mul_a = 33'(push_y);
        mul_b = {1'b0, fric_dt};
      end
      STEP_SQ_NX: begin
        mul_a = 33'(tmp_a);
        mul_b = 33'(tmp_a);
      end
      STEP_SQ_NY: begin
        mul_a = 33'(tmp_b);
        mul_b = 33'(tmp_b);
      end
      STEP_MUL_HD: begin
        mul_a = 33'(ang_speed);
        mul_b = dt_s;
      end
      STEP_MUL_TX, STEP_MUL_TY: begin
        mul_a = travel;
        mul_b = dt_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration and body state.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass    <= INV_MASS_RST;
      max_speed_x <= MAX_SPEED_RST;
      max_speed_y <= MAX_SPEED_RST;
      friction    <= FRICTION_RST;
      ang_speed   <= '0;
      vel_x       <= '0;
      vel_y       <= '0;
      push_x      <= '0;
      push_y      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INV_MASS:    inv_mass    <= cfg_data;
          CFG_MAX_SPEED_X: max_speed_x <= cfg_data[30:0];
          CFG_MAX_SPEED_Y: max_speed_y <= cfg_data[30:0];
          CFG_FRICTION:    friction    <= cfg_data[15:0];
          CFG_ANG_SPEED:   ang_speed   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.capture && in_item.load_knockback) begin
        push_x <= in_item.knockback_x;
        push_y <= in_item.knockback_y;
      end
      if (cmd.run) begin
        unique case (cmd.step)
          STEP_MUL_DVY: begin
            vel_x <= sat32(68'(vel_x) + 68'(gain));
          end
          STEP_MUL_FD: begin
            vel_y <= sat32(68'(vel_y) + 68'(gain));
            vel_x <= clamp_axis(vel_x, max_speed_x);
          end
          STEP_SQ_PX: begin
            vel_y <= clamp_axis(vel_y, max_speed_y);
          end
          STEP_PUSH: begin
            // A decayed push shorter than 1.0 snaps to rest.
            if (decay) begin
              if (lensq_sum[63:32] == '0) begin
                push_x <= '0;
                push_y <= '0;
              end else begin
                push_x <= tmp_a;
                push_y <= tmp_b;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.capture) begin
      item <= in_item;
    end
    if (cmd.run) begin
      unique case (cmd.step)
        STEP_MUL_AY:  tmp_a <= gain;
        STEP_MUL_DVX: tmp_b <= gain;
        STEP_SQ_PX:   fric_dt <= prod[31:0];
        STEP_SQ_PY:   lensq <= prod[63:0];
        STEP_DEC_X:   lensq <= lensq_sum;
        STEP_DEC_Y: begin
          tmp_a <= sat32(68'(push_x) - 68'(p_q24));
          decay <= (lensq > LENSQ_MIN_DECAY);
        end
        STEP_SQ_NX:   tmp_b <= sat32(68'(push_y) - 68'(p_q24));
        STEP_SQ_NY:   lensq <= prod[63:0];
        STEP_MUL_HD:  travel <= 33'(vel_x) + 33'(push_x);
        STEP_MUL_TX: begin
          head_n <= sat32(68'(item.heading) + 68'(p_q16));
          travel <= 33'(vel_y) + 33'(push_y);
        end
        STEP_MUL_TY:  pos_x_n <= sat32(68'(item.position_x) + 68'(p_q16));
        STEP_POS_Y:   pos_y_n <= sat32(68'(item.position_y) + 68'(p_q16));
        default: begin
        end
      endcase
    end
    if (cmd.load_out) begin
      out_item.new_position_x   <= pos_x_n;
      out_item.new_position_y   <= pos_y_n;
      out_item.new_heading      <= head_n;
      out_item.speed_x          <= vel_x;
      out_item.speed_y          <= vel_y;
      out_item.knockback_active <= (push_x != '0) || (push_y != '0);
    end
  end

endmodule

@@ design/rigid_body_euler_step.sv @@
// Rigid body Euler step: one request per frame tick updates the stored
// velocity and knockback of a 2D body and returns its new pose. A request
// is taken only when the block is idle, so the next request is taken only
// after the last result has moved to the output register. Each request runs
// through sixteen controller steps, in which fourteen products pass one after
// another through the single shared 33x33 multiplier; the result then loads
// into the output register once that is free, as the block returns to idle.
// A result not yet taken holds in the output register while the next request
// is accepted and computed.
module rigid_body_euler_step import rbes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rbes_stream_if.sink           in_ch,
  rbes_stream_if.source         out_ch
);

  rbes_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  rbes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rbes_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_item   (in_ch.data),
    .out_item  (out_item)
  );

endmodule

@@ design/rbes_checker.sv @@
// Port-level checks of the rigid body Euler step, bound to the top level.
// Depends on rbes_pkg and rigid_body_euler_step_defines.svh.
`include "rigid_body_euler_step_defines.svh"

module rbes_checker import rbes_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `RBES_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `RBES_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")
  `RBES_ASSERT_IMP(a_idle_on_result, $rose(out_valid), in_ready, "not idle when result appears")

endmodule

bind rigid_body_euler_step rbes_checker u_rbes_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

@@ dv/rigid_body_euler_step_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rigid_body_euler_step: a queue-fed driver, a
// monitor and a fixed-point predictor of the velocity, knockback and pose update.
// Depends on rbes_pkg and rbes_stream_if from the design.
module rigid_body_euler_step_tb;
  import rbes_pkg::*;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [63:0] LENSQ_ONE = 64'h1_0000_0000;
  localparam int HOLD_AT_RESULT = 130;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rbes_stream_if #(.item_t(in_item_t))  in_ch ();
  rbes_stream_if #(.item_t(out_item_t)) out_ch ();

  rigid_body_euler_step dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Predictor copy of the registers and of the body state.
  logic        [31:0] inv_mass_cfg;
  logic        [30:0] max_x_cfg;
  logic        [30:0] max_y_cfg;
  logic        [15:0] friction_cfg;
  logic signed [31:0] spin_cfg;
  logic signed [31:0] body_vx;
  logic signed [31:0] body_vy;
  logic signed [31:0] knock_x;
  logic signed [31:0] knock_y;

  in_item_t  pending_requests[$];
  out_item_t expected_poses[$];
  out_item_t want_pose;

  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned knock_loads;
  int unsigned settings_used;
  int unsigned fault_count;
  int unsigned taken;
  int unsigned send_gap;
  int unsigned ready_gap;
  int unsigned long_hold;
  bit          held_once;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d requests accepted, %0d results seen",
             items_accepted, items_queued, results_seen);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_axis(logic signed [31:0] v, logic [30:0] lim);
    longint m;
    longint neg;
    m = longint'(lim);
    neg = -m;
    if (longint'(v) > m) return m[31:0];
    if (longint'(v) < neg) return neg[31:0];
    return v;
  endfunction

  function automatic logic [63:0] knock_lensq();
    longint      x;
    longint      y;
    logic [63:0] sx;
    logic [63:0] sy;
    x = knock_x;
    y = knock_y;
    sx = x * x;
    sy = y * y;
    return sx + sy;
  endfunction

  // Advances the body by one frame and returns the pose the block should report.
  function automatic out_item_t advance_body(in_item_t req);
    longint    dt;
    longint    ax;
    longint    ay;
    longint    fd;
    longint    dx;
    longint    dy;
    longint    fvx;
    longint    fvy;
    out_item_t res;
    dt = longint'(req.step_time);
    if (req.load_knockback) begin
      knock_x = req.knockback_x;
      knock_y = req.knockback_y;
    end
    ax = sat32((longint'($signed(req.force_x)) * longint'(inv_mass_cfg)) >>> 16);
    ay = sat32((longint'($signed(req.force_y)) * longint'(inv_mass_cfg)) >>> 16);
    body_vx = clamp_axis(sat32(longint'(body_vx) + sat32((ax * dt) >>> 16)), max_x_cfg);
    body_vy = clamp_axis(sat32(longint'(body_vy) + sat32((ay * dt) >>> 16)), max_y_cfg);

    if (knock_lensq() > LENSQ_MIN_DECAY) begin
      // Friction times step time is Q8.24.
      fd = longint'(friction_cfg) * dt;
      dx = (longint'(knock_x) * fd) >>> 24;
      dy = (longint'(knock_y) * fd) >>> 24;
      knock_x = sat32(longint'(knock_x) - dx);
      knock_y = sat32(longint'(knock_y) - dy);
      if (knock_lensq() < LENSQ_ONE) begin
        knock_x = '0;
        knock_y = '0;
      end
    end

    fvx = longint'(body_vx) + longint'(knock_x);
    fvy = longint'(body_vy) + longint'(knock_y);
    res.new_position_x = sat32(longint'($signed(req.position_x)) + ((fvx * dt) >>> 16));
    res.new_position_y = sat32(longint'($signed(req.position_y)) + ((fvy * dt) >>> 16));
    res.new_heading = sat32(longint'($signed(req.heading)) + ((longint'(spin_cfg) * dt) >>> 16));
    res.speed_x = body_vx;
    res.speed_y = body_vy;
    res.knockback_active = (knock_x != 0) || (knock_y != 0);
    return res;
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      note_fault($sformatf("result %0d %s expected %h got %h", results_seen, name, want, got));
  endfunction

  function automatic in_item_t pack_request(logic [31:0] fx, logic [31:0] fy, logic ld,
                                           logic [31:0] kx, logic [31:0] ky, logic [15:0] dt,
                                           logic [31:0] px, logic [31:0] py, logic [31:0] hd);
    in_item_t req;
    req.force_x = fx;
    req.force_y = fy;
    req.load_knockback = ld;
    req.knockback_x = kx;
    req.knockback_y = ky;
    req.step_time = dt;
    req.position_x = px;
    req.position_y = py;
    req.heading = hd;
    return req;
  endfunction

  // Mostly moderate magnitudes, some below one so the knockback cutoffs are hit,
  // and now and then any bit pattern at all.
  function automatic logic [31:0] rand_q16();
    int unsigned k;
    logic [31:0] v;
    if ($urandom_range(0, 9) == 0) return $urandom();
    k = $urandom_range(4, 24);
    v = $urandom() & ((32'd1 << k) - 32'd1);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic in_item_t random_request();
    logic [15:0] dt;
    case ($urandom_range(0, 9))
      0: dt = '0;
      1: dt = $urandom_range(0, 65535);
      default: dt = $urandom_range(200, 4400);
    endcase
    return pack_request(rand_q16(), rand_q16(), $urandom_range(0, 7) == 0,
                        rand_q16(), rand_q16(), dt, rand_q16(), rand_q16(), rand_q16());
  endfunction

  task automatic queue_request(in_item_t req);
    pending_requests.push_back(req);
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_INV_MASS:    inv_mass_cfg = value;
      CFG_MAX_SPEED_X: max_x_cfg = value[30:0];
      CFG_MAX_SPEED_Y: max_y_cfg = value[30:0];
      CFG_FRICTION:    friction_cfg = value[15:0];
      CFG_ANG_SPEED:   spin_cfg = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [31:0] inv, logic [31:0] mx, logic [31:0] my,
                               logic [31:0] fr, logic [31:0] ang);
    write_reg(CFG_INV_MASS, inv);
    write_reg(CFG_MAX_SPEED_X, mx);
    write_reg(CFG_MAX_SPEED_Y, my);
    write_reg(CFG_FRICTION, fr);
    write_reg(CFG_ANG_SPEED, ang);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Registers change only once every request has produced its result and the
  // block has had time to settle.
  task automatic wait_drained();
    while (items_accepted != items_queued || expected_poses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_poses.push_back(advance_body(in_ch.data));
        items_accepted++;
        if (in_ch.data.load_knockback) knock_loads++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_ch.data <= pending_requests.pop_front();
          in_ch.valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: short random stalls, plus one long hold-off so the block
  // backs up and stalls its request side.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      ready_gap <= 0;
      long_hold <= 0;
      held_once <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) taken++;
      if (long_hold != 0) begin
        long_hold <= long_hold - 1;
        out_ch.ready <= 1'b0;
      end else if (!held_once && taken == HOLD_AT_RESULT) begin
        held_once <= 1'b1;
        long_hold <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (ready_gap != 0) begin
        ready_gap <= ready_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        ready_gap <= $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_poses.size() == 0) begin
        note_fault($sformatf("result %0d arrived with no request outstanding", results_seen));
      end else begin
        want_pose = expected_poses.pop_front();
        check_field("new_position_x", want_pose.new_position_x, out_ch.data.new_position_x);
        check_field("new_position_y", want_pose.new_position_y, out_ch.data.new_position_y);
        check_field("new_heading", want_pose.new_heading, out_ch.data.new_heading);
        check_field("speed_x", want_pose.speed_x, out_ch.data.speed_x);
        check_field("speed_y", want_pose.speed_y, out_ch.data.speed_y);
        check_field("knockback_active", want_pose.knockback_active,
                    out_ch.data.knockback_active);
      end
    end
  end

  initial begin
    int unsigned waited;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_INV_MASS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    calm = 1'b0;
    inv_mass_cfg = INV_MASS_RST;
    max_x_cfg = MAX_SPEED_RST;
    max_y_cfg = MAX_SPEED_RST;
    friction_cfg = FRICTION_RST;
    spin_cfg = '0;
    body_vx = '0;
    body_vy = '0;
    knock_x = '0;
    knock_y = '0;
    settings_used = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: saturation, knockback decay and both cutoffs.
    queue_request(pack_request('0, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    queue_request(pack_request(Q_MAX, Q_MIN, 1'b0, '0, '0, 16'hFFFF, '0, '0, '0));
    queue_request(pack_request(Q_MAX, Q_MIN, 1'b0, '0, '0, 16'hFFFF, Q_MAX, Q_MIN, '0));
    queue_request(pack_request(Q_MIN, Q_MAX, 1'b0, '0, '0, 16'hFFFF, Q_MIN, Q_MAX, '0));
    queue_request(pack_request('0, '0, 1'b1, 32'h000A_0000, 32'hFFFB_0000, 16'd1092,
                               '0, '0, '0));
    repeat (3) queue_request(pack_request('0, '0, 1'b0, '0, '0, 16'd1092, Q_ONE, Q_ONE, '0));
    // A knockback too small to decay stays active, also with zero step time.
    queue_request(pack_request('0, '0, 1'b1, 32'h20, 32'h20, 16'd1092, '0, '0, '0));
    queue_request(pack_request('0, '0, 1'b0, '0, '0, '0, '0, '0, '0));
    // Between the two thresholds: zeroed even though the step time is zero.
    queue_request(pack_request('0, '0, 1'b1, 32'h8000, '0, '0, '0, '0, '0));
    queue_request(pack_request('0, '0, 1'b1, 32'h0001_0100, '0, '0, '0, '0, '0));
    queue_request(pack_request('0, '0, 1'b1, Q_MAX, Q_MIN, 16'hFFFF, Q_MAX, Q_MIN, '0));
    queue_request(pack_request('0, '0, 1'b0, '0, '0, 16'hFFFF, Q_MAX, Q_MIN, '0));
    queue_request(pack_request('0, '0, 1'b1, Q_MIN, Q_MIN, 16'hFFFF, Q_MIN, Q_MIN, Q_MAX));
    queue_request(pack_request(32'hFFFF_FFFF, '0, 1'b0, '0, '0, 16'd1, '0, '0, '0));
    queue_request(pack_request('1, '1, 1'b1, '1, '1, 16'hFFFF, '1, '1, '1));
    queue_request(pack_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 32'h5555_5555,
                               32'hAAAA_AAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                               32'hAAAA_AAAA));
    queue_request(pack_request(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA,
                               32'h5555_5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                               32'h5555_5555));

    // Heaviest friction and largest inverse mass: the decay overshoots and flips
    // the knockback; bits above each register's width are ignored.
    wait_drained();
    load_settings(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_request(pack_request(Q_ONE, Q_MIN, 1'b1, 32'h0010_0000, 32'hFFF0_0000, 16'hFFFF,
                               '0, '0, Q_MIN));
    queue_request(pack_request('0, '0, 1'b1, 32'h0010_0000, 32'hFFF0_0000, 16'h8000,
                               '0, '0, '0));
    queue_request(pack_request('0, '0, 1'b0, '0, '0, 16'd1092, '0, '0, '0));
    repeat (70) queue_request(random_request());

    wait_drained();
    load_settings('0, 32'h7FFF_FFFF, '0, '0, 32'h7FFF_FFFF);
    queue_request(pack_request(Q_MAX, Q_MAX, 1'b1, Q_ONE, Q_ONE, 16'hFFFF, '0, '0, Q_MAX));
    queue_request(pack_request(Q_MIN, Q_MIN, 1'b0, '0, '0, 16'hFFFF, '0, '0, '0));
    repeat (80) queue_request(random_request());

    for (int p = 0; p < 3; p++) begin
      wait_drained();
      if (p == 2) begin
        @(posedge clk);
        calm <= 1'b1;
      end
      load_settings($urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000) : $urandom(),
                    $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(32'h1000, 32'h20_0000),
                    $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(32'h1000, 32'h20_0000),
                    $urandom(), rand_q16());
      repeat (80) queue_request(random_request());
    end

    waited = 0;
    while ((items_accepted != items_queued || expected_poses.size() != 0) && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (expected_poses.size() != 0 || items_accepted != items_queued)
      note_fault($sformatf("%0d requests unaccepted, %0d results never arrived",
                           items_queued - items_accepted, expected_poses.size()));

    $display("Sent %0d requests under %0d register settings; %0d results checked, %0d loaded knockback.",
             items_accepted, settings_used, results_seen, knock_loads);
    $display("Exercised saturation, knockback decay, overshoot and cutoffs, zero step time and a long output stall.");
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
